[hdl/brb_pkg.sv]
`timescale 1ns / 1ps

package brb_pkg;

  localparam int CAPACITY    = 4096;
  localparam int CHECKPOINTS = 8;

  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int FILL_W   = 13;
  localparam int SP_W     = $clog2(CHECKPOINTS + 1);
  localparam int SP_IDX_W = (CHECKPOINTS > 1) ? $clog2(CHECKPOINTS) : 1;

  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_PUSH    = 3'd2;
  localparam logic [2:0] CMD_RESTORE = 3'd3;
  localparam logic [2:0] CMD_DROP    = 3'd4;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_FULL        = 3'd2,
    ST_STACK_FULL  = 3'd3,
    ST_STACK_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

[hdl/brb_ifs.sv]
`timescale 1ns / 1ps

interface brb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] data_in;

  modport source (output valid, cmd, data_in, input ready);
  modport sink   (input valid, cmd, data_in, output ready);
endinterface

interface brb_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_out;
  logic [2:0]  status;
  logic [12:0] fill_level;

  modport source (output valid, data_out, status, fill_level, input ready);
  modport sink   (input valid, data_out, status, fill_level, output ready);
endinterface

[hdl/brb_ctrl.sv]
`timescale 1ns / 1ps

module brb_ctrl
  import brb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!sts.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/brb_dp.sv]
`timescale 1ns / 1ps

module brb_dp
  import brb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_out,
  output logic [2:0]  out_status,
  output logic [12:0] out_fill_level
);

  logic [7:0]        mem [CAPACITY];
  logic [2:0]        cmd_r;
  logic [7:0]        din_r;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [PTR_W-1:0]  stk_rp   [CHECKPOINTS];
  logic [FILL_W-1:0] stk_fill [CHECKPOINTS];
  logic [7:0]        mem_q_r;
  logic              rd_ok_r;
  status_t           res_status_r, res_status_nxt;
  logic              out_valid_r;
  logic [7:0]        out_data_r;
  status_t           out_status_r;
  logic [FILL_W-1:0] out_fill_r;

  logic              wr_en, rd_en, stk_wr;
  logic [FILL_W:0]   wsum;
  logic [PTR_W-1:0]  wp;
  logic [SP_W-1:0]   sp_dec;
  logic [SP_IDX_W-1:0] top_idx, wr_idx;

  assign wsum    = (FILL_W+1)'(rp_r) + (FILL_W+1)'(fill_r);
  assign wp      = (wsum >= (FILL_W+1)'(CAPACITY)) ?
                   PTR_W'(wsum - (FILL_W+1)'(CAPACITY)) : PTR_W'(wsum);
  assign sp_dec  = sp_r - 1'b1;
  assign top_idx = sp_dec[SP_IDX_W-1:0];
  assign wr_idx  = sp_r[SP_IDX_W-1:0];

  always_comb begin
    rp_nxt         = rp_r;
    fill_nxt       = fill_r;
    sp_nxt         = sp_r;
    res_status_nxt = ST_OK;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    stk_wr         = 1'b0;
    case (cmd_r)
      CMD_WRITE: begin
        if (fill_r == FILL_W'(CAPACITY)) begin
          res_status_nxt = ST_FULL;
        end else begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
      end
      CMD_READ: begin
        if (fill_r == '0) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          rp_nxt   = (rp_r == PTR_W'(CAPACITY - 1)) ? '0 : rp_r + 1'b1;
          fill_nxt = fill_r - 1'b1;
        end
      end
      CMD_PUSH: begin
        if (sp_r == SP_W'(CHECKPOINTS)) begin
          res_status_nxt = ST_STACK_FULL;
        end else begin
          stk_wr = 1'b1;
          sp_nxt = sp_r + 1'b1;
        end
      end
      CMD_RESTORE: begin
        if (sp_r == '0) begin
          res_status_nxt = ST_STACK_EMPTY;
        end else begin
          sp_nxt   = sp_dec;
          rp_nxt   = stk_rp[top_idx];
          fill_nxt = stk_fill[top_idx];
        end
      end
      CMD_DROP: begin
        if (sp_r == '0) begin
          res_status_nxt = ST_STACK_EMPTY;
        end else begin
          sp_nxt = sp_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wp] <= din_r;
    end
    if (cmd.exec && rd_en) begin
      mem_q_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && stk_wr) begin
      stk_rp[wr_idx]   <= rp_r;
      stk_fill[wr_idx] <= fill_r;
    end
    if (cmd.load) begin
      cmd_r <= in_cmd;
      din_r <= in_data_in;
    end
    if (cmd.exec) begin
      rd_ok_r      <= rd_en;
      res_status_r <= res_status_nxt;
    end
    if (cmd.push) begin
      out_data_r   <= rd_ok_r ? mem_q_r : 8'd0;
      out_status_r <= res_status_r;
      out_fill_r   <= fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      fill_r      <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        rp_r   <= rp_nxt;
        fill_r <= fill_nxt;
        sp_r   <= sp_nxt;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_busy   = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_status     = out_status_r;
  assign out_fill_level = out_fill_r;

endmodule

[hdl/byte_ring_buffer_with_checkpoints_top.sv]
`timescale 1ns / 1ps

// Circular byte FIFO of 4096 bytes with an 8-deep checkpoint stack. Each input
// beat carries a command and a byte and yields exactly one result beat with the
// byte read, a status and the fill level after the command. An item passes these
// steps in order: the cycle in which its beat is accepted and captured, a step
// that updates the pointers, the checkpoint stack and the byte store
// (single-port access), and a step that hands the result over. The result moves
// into the output register at the end of the hand-over step. A waiting result
// holds the item in the hand-over step. A new beat is taken in the cycle after
// the previous result has moved into the output register, even while that
// result still waits, so no new beat is taken while an item is in flight.
// The byte store holds no reset state; there is no clearing pass after reset.
module byte_ring_buffer_with_checkpoints_top
  import brb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  brb_in_if.sink     in_ch,
  brb_out_if.source  out_ch
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  brb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .sts            (dp_sts),
    .in_cmd         (in_ch.cmd),
    .in_data_in     (in_ch.data_in),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_data_out   (out_ch.data_out),
    .out_status     (out_ch.status),
    .out_fill_level (out_ch.fill_level)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in flight");

  a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> dp_cmd.exec)
    else $error("accepted beat not executed");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.push |-> !dp_sts.out_busy)
    else $error("result pushed over a waiting result");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.fill_level <= 13'(CAPACITY)))
    else $error("fill level beyond capacity");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import brb_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 10;
  localparam int FILL_ITEMS   = 48;
  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_ITEMS  = 100;

  class fifo_scoreboard;
    typedef struct {
      logic [7:0]        data;
      status_t           status;
      logic [FILL_W-1:0] level;
    } fifo_result_t;

    logic [7:0]        byte_mem [CAPACITY];
    logic [PTR_W-1:0]  rd_ptr;
    logic [FILL_W-1:0] fill;
    logic [PTR_W-1:0]  mark_ptr [CHECKPOINTS];
    logic [FILL_W-1:0] mark_fill [CHECKPOINTS];
    int                mark_depth;
    fifo_result_t      expected_q [$];
    int                errors;

    function new();
      rd_ptr     = '0;
      fill       = '0;
      mark_depth = 0;
      errors     = 0;
    endfunction

    function void note_command(logic [2:0] cmd, logic [7:0] data);
      fifo_result_t     r;
      logic [PTR_W-1:0] wr_ptr;
      r.data   = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_WRITE: begin
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            wr_ptr = rd_ptr + fill[PTR_W-1:0];
            byte_mem[wr_ptr] = data;
            fill++;
          end
        end
        CMD_READ: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data = byte_mem[rd_ptr];
            rd_ptr++;
            fill--;
          end
        end
        CMD_PUSH: begin
          if (mark_depth >= CHECKPOINTS) begin
            r.status = ST_STACK_FULL;
          end else begin
            mark_ptr[mark_depth]  = rd_ptr;
            mark_fill[mark_depth] = fill;
            mark_depth++;
          end
        end
        CMD_RESTORE: begin
          if (mark_depth == 0) begin
            r.status = ST_STACK_EMPTY;
          end else begin
            mark_depth--;
            rd_ptr = mark_ptr[mark_depth];
            fill   = mark_fill[mark_depth];
          end
        end
        CMD_DROP: begin
          if (mark_depth == 0) begin
            r.status = ST_STACK_EMPTY;
          end else begin
            mark_depth--;
          end
        end
        default: begin
        end
      endcase
      r.level = fill;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [7:0] data, logic [2:0] status,
                               logic [FILL_W-1:0] level);
      fifo_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: data_out %0d status %0d fill_level %0d",
               data, status, level);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (data !== exp_r.data) begin
        $error("data_out: expected %0d, got %0d", exp_r.data, data);
        errors++;
      end
      if (status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, status);
        errors++;
      end
      if (level !== exp_r.level) begin
        $error("fill_level: expected %0d, got %0d", exp_r.level, level);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  bit   hold_req;
  int   counted_items;
  int   idle_cycles;

  brb_in_if  in_ch ();
  brb_out_if out_ch ();

  fifo_scoreboard sb = new();

  byte_ring_buffer_with_checkpoints_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_command(in_ch.cmd, in_ch.data_in);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.data_out, out_ch.status, out_ch.fill_level);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [2:0] cmd, input logic [7:0] data);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.data_in <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd <= CMD_DROP) counted_items++;
  endtask

  task automatic send_rw();
    if ($urandom_range(0, 99) < 55) begin
      send_item(CMD_WRITE, 8'($urandom));
    end else begin
      send_item(CMD_READ, 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int nest;
    int start_count;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_WRITE;
    in_ch.data_in <= '0;
    rst_n         <= 1'b0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    counted_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_READ, 8'h00);
    send_item(CMD_RESTORE, 8'hFF);
    send_item(CMD_DROP, 8'hFF);
    for (int c = CMD_DROP + 1; c < 8; c++) send_item(3'(c), 8'hFF);
    send_item(CMD_WRITE, 8'h00);
    send_item(CMD_WRITE, 8'hFF);
    send_item(CMD_PUSH, 8'h00);
    send_item(CMD_READ, 8'h00);
    send_item(CMD_WRITE, 8'h5A);
    send_item(CMD_RESTORE, 8'h00);
    send_item(CMD_READ, 8'h00);
    repeat (CHECKPOINTS + 1) send_item(CMD_PUSH, 8'h00);
    send_item(CMD_RESTORE, 8'h00);
    repeat (CHECKPOINTS) send_item(CMD_DROP, 8'h00);
    wait_drained();

    // hold off the receiver while the sender keeps writing
    hold_req = 1'b1;
    repeat (FILL_ITEMS - 1) send_item(CMD_WRITE, 8'($urandom));
    send_item(CMD_WRITE, 8'hC3);
    // read and write past a checkpoint, then roll back
    send_item(CMD_PUSH, 8'($urandom));
    repeat (3) send_item(CMD_READ, 8'($urandom));
    repeat (3) send_item(CMD_WRITE, 8'($urandom));
    send_item(CMD_RESTORE, 8'($urandom));
    repeat (FILL_ITEMS + 2) send_item(CMD_READ, 8'($urandom));
    wait_drained();

    start_count = counted_items;
    while (counted_items - start_count < RANDOM_ITEMS) begin
      if (counted_items - start_count >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      if ($urandom_range(0, 9) < 8) begin
        nest = $urandom_range(1, CHECKPOINTS + 1);
        repeat (nest) begin
          send_item(CMD_PUSH, 8'($urandom));
          repeat ($urandom_range(1, 6)) send_rw();
        end
        repeat (nest) begin
          send_item(($urandom_range(0, 2) == 0) ? CMD_DROP : CMD_RESTORE, 8'($urandom));
          repeat ($urandom_range(0, 4)) send_rw();
        end
      end else begin
        send_item(3'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
